FILE: rtl/mfsd_pkg.sv
// mfsd_pkg: shared constants, types and the seven-segment lookup
// for the meter frame segment decoder; no dependencies
package mfsd_pkg;

    localparam int FRAME_LENGTH = 22;
    localparam int IDX_W        = $clog2(FRAME_LENGTH);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(FRAME_LENGTH - 1);

    localparam logic [7:0] SYNC_RESET = 8'hAA;

    // frame byte positions
    localparam int POS_DIGIT0 = 6;
    localparam int POS_DIGIT1 = 7;
    localparam int POS_DIGIT2 = 8;
    localparam int POS_DIGIT3 = 9;
    localparam int POS_MODE   = 10;
    localparam int POS_HOLD   = 18;
    localparam int POS_EXTRA  = 19;
    localparam int POS_PREFIX = 20;
    localparam int POS_UNIT   = 21;

    localparam logic [7:0] SEG_MASK   = 8'h7F;
    localparam logic [7:0] SIGN_MASK  = 8'h18;
    localparam logic [7:0] MODE_MASK  = 8'hE7;
    localparam logic [7:0] HOLD_MASK  = 8'hF0;
    localparam logic [7:0] EXTRA_MASK = 8'hFE;

    localparam int SEG_COUNT = 12;
    localparam logic [3:0] CODE_UNKNOWN = 4'd12;

    // pattern k maps to digit code k: blank, 0..9, L
    localparam logic [6:0] SEG_TABLE [SEG_COUNT] = '{
        7'h00, 7'h5F, 7'h06, 7'h6B, 7'h2F, 7'h36,
        7'h3D, 7'h7D, 7'h07, 7'h7F, 7'h3F, 7'h58
    };

    typedef struct packed {
        logic [7:0]       mode_byte;
        logic [3:0][7:0]  digit_bytes;
        logic [7:0]       hold_byte;
        logic [7:0]       extra_byte;
        logic [7:0]       prefix_byte;
        logic [7:0]       unit_byte;
    } frame_t;

    typedef struct packed {
        logic             negative;
        logic [3:0][3:0]  digits;
        logic [3:0]       decimal_points;
        logic [7:0]       unit_prefix_flags;
        logic [7:0]       unit_flags;
        logic [7:0]       mode_flags;
        logic [7:0]       hold_flags;
        logic [7:0]       extra_flags;
    } result_t;

    function automatic logic [3:0] seg_to_code(input logic [7:0] b);
        logic [6:0] pat;
        logic [3:0] code;
        pat  = b[6:0];
        code = CODE_UNKNOWN;
        for (int i = SEG_COUNT - 1; i >= 0; i--) begin
            if (SEG_TABLE[i] == pat) begin
                code = 4'(i);
            end
        end
        return code;
    endfunction

endpackage

FILE: rtl/mfsd_collect.sv
// mfsd_collect: sync register, byte position counter and frame capture
// depends on mfsd_pkg
module mfsd_collect (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_wr_en,
    input  logic [7:0]           cfg_wr_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [7:0]           s_rx_byte,
    output logic                 frame_valid,
    input  logic                 frame_ready,
    output mfsd_pkg::frame_t     frame
);

    logic [7:0]                  sync_byte_reg;
    logic [mfsd_pkg::IDX_W-1:0]  byte_index_reg;
    logic [mfsd_pkg::IDX_W-1:0]  byte_index_next;
    logic [mfsd_pkg::IDX_W-1:0]  idx_eff;
    logic [7:0] keep_reg [mfsd_pkg::POS_DIGIT0:mfsd_pkg::POS_UNIT];
    logic [7:0] view     [mfsd_pkg::POS_DIGIT0:mfsd_pkg::POS_UNIT];
    logic                        frame_valid_reg;
    logic                        frame_valid_next;
    mfsd_pkg::frame_t            frame_reg;
    mfsd_pkg::frame_t            frame_next;
    logic                        accept;
    logic                        last;

    assign s_ready     = !frame_valid_reg || frame_ready;
    assign accept      = s_valid && s_ready;
    assign frame_valid = frame_valid_reg;
    assign frame       = frame_reg;

    always_comb begin
        idx_eff = (s_rx_byte == sync_byte_reg) ? '0 : byte_index_reg;
        last    = (idx_eff == mfsd_pkg::LAST_IDX);
        byte_index_next = byte_index_reg;
        if (accept) begin
            byte_index_next = last ? '0 : idx_eff + 1'b1;
        end
        // current word overrides its own position
        for (int p = mfsd_pkg::POS_DIGIT0; p <= mfsd_pkg::POS_UNIT; p++) begin
            view[p] = (idx_eff == mfsd_pkg::IDX_W'(p)) ? s_rx_byte : keep_reg[p];
        end
        frame_next.mode_byte      = view[mfsd_pkg::POS_MODE];
        frame_next.digit_bytes[0] = view[mfsd_pkg::POS_DIGIT0];
        frame_next.digit_bytes[1] = view[mfsd_pkg::POS_DIGIT1];
        frame_next.digit_bytes[2] = view[mfsd_pkg::POS_DIGIT2];
        frame_next.digit_bytes[3] = view[mfsd_pkg::POS_DIGIT3];
        frame_next.hold_byte      = view[mfsd_pkg::POS_HOLD];
        frame_next.extra_byte     = view[mfsd_pkg::POS_EXTRA];
        frame_next.prefix_byte    = view[mfsd_pkg::POS_PREFIX];
        frame_next.unit_byte      = view[mfsd_pkg::POS_UNIT];
        frame_valid_next = frame_valid_reg;
        if (frame_valid_reg && frame_ready) begin
            frame_valid_next = 1'b0;
        end
        if (accept && last) begin
            frame_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sync_byte_reg   <= mfsd_pkg::SYNC_RESET;
            byte_index_reg  <= '0;
            frame_valid_reg <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                sync_byte_reg <= cfg_wr_data;
            end
            byte_index_reg  <= byte_index_next;
            frame_valid_reg <= frame_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int p = mfsd_pkg::POS_DIGIT0; p <= mfsd_pkg::POS_UNIT; p++) begin
                keep_reg[p] <= view[p];
            end
            if (last) begin
                frame_reg <= frame_next;
            end
        end
    end

endmodule

FILE: rtl/mfsd_decode.sv
// mfsd_decode: segment lookup and flag masking into the result register
// depends on mfsd_pkg
module mfsd_decode (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 frame_valid,
    output logic                 frame_ready,
    input  mfsd_pkg::frame_t     frame,
    output logic                 m_valid,
    input  logic                 m_ready,
    output mfsd_pkg::result_t    result
);

    logic                 m_valid_reg;
    logic                 m_valid_next;
    mfsd_pkg::result_t    result_reg;
    mfsd_pkg::result_t    result_next;

    assign frame_ready = !m_valid_reg || m_ready;
    assign m_valid     = m_valid_reg;
    assign result      = result_reg;

    always_comb begin
        result_next.negative = |(frame.mode_byte & mfsd_pkg::SIGN_MASK);
        for (int k = 0; k < 4; k++) begin
            result_next.digits[k]         = mfsd_pkg::seg_to_code(frame.digit_bytes[k]);
            result_next.decimal_points[k] = frame.digit_bytes[k][7];
        end
        result_next.unit_prefix_flags = frame.prefix_byte;
        result_next.unit_flags        = frame.unit_byte;
        result_next.mode_flags        = frame.mode_byte & mfsd_pkg::MODE_MASK;
        result_next.hold_flags        = frame.hold_byte & mfsd_pkg::HOLD_MASK;
        result_next.extra_flags       = frame.extra_byte & mfsd_pkg::EXTRA_MASK;
        m_valid_next = m_valid_reg;
        if (frame_ready) begin
            m_valid_next = frame_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_valid && frame_ready) begin
            result_reg <= result_next;
        end
    end

endmodule

FILE: rtl/meter_frame_segment_decoder.sv
// meter_frame_segment_decoder: top level, collector feeding the decoder
// depends on mfsd_pkg, mfsd_collect, mfsd_decode
//
//   channel   direction  handshake           payload
//   s_        in         s_valid / s_ready   s_rx_byte, one link word
//   m_        out        m_valid / m_ready   one decoded reading per frame
//
// one word accepted per cycle while s_ready is high
// sync register resets to 0xAA, position counter to zero, no clearing pass
// the frame register and the result register each hold one reading, so words
// keep flowing while one reading waits; once a second frame completes before the
// first reading is taken both are full and s_ready stays low until m_ready
module meter_frame_segment_decoder (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [7:0]  cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_rx_byte,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_negative,
    output logic [3:0]  m_digit_3,
    output logic [3:0]  m_digit_2,
    output logic [3:0]  m_digit_1,
    output logic [3:0]  m_digit_0,
    output logic [3:0]  m_decimal_points,
    output logic [7:0]  m_unit_prefix_flags,
    output logic [7:0]  m_unit_flags,
    output logic [7:0]  m_mode_flags,
    output logic [7:0]  m_hold_flags,
    output logic [7:0]  m_extra_flags
);

    logic                 frame_valid;
    logic                 frame_ready;
    mfsd_pkg::frame_t     frame;
    mfsd_pkg::result_t    result;

    mfsd_collect u_collect (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_rx_byte   (s_rx_byte),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame)
    );

    mfsd_decode u_decode (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .frame_valid (frame_valid),
        .frame_ready (frame_ready),
        .frame       (frame),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .result      (result)
    );

    assign m_negative          = result.negative;
    assign m_digit_3           = result.digits[3];
    assign m_digit_2           = result.digits[2];
    assign m_digit_1           = result.digits[1];
    assign m_digit_0           = result.digits[0];
    assign m_decimal_points    = result.decimal_points;
    assign m_unit_prefix_flags = result.unit_prefix_flags;
    assign m_unit_flags        = result.unit_flags;
    assign m_mode_flags        = result.mode_flags;
    assign m_hold_flags        = result.hold_flags;
    assign m_extra_flags       = result.extra_flags;

`ifndef SYNTHESIS
    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (frame_valid && m_valid && !m_ready))
        else $error("input stalled while a stage is free");

    a_frame_reaches_output: assert property (@(posedge aclk) disable iff (!aresetn)
        (frame_valid && frame_ready) |=> m_valid)
        else $error("captured frame lost before the result register");

    a_drain_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_ready && !frame_valid) |=> !m_valid)
        else $error("reading repeated after being taken");

    a_digit_codes: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_digit_0 <= mfsd_pkg::CODE_UNKNOWN) && (m_digit_1 <= mfsd_pkg::CODE_UNKNOWN)
            && (m_digit_2 <= mfsd_pkg::CODE_UNKNOWN) && (m_digit_3 <= mfsd_pkg::CODE_UNKNOWN))
        else $error("digit code out of range");
`endif

endmodule

FILE: test/mfsd_reading_checker.sv
`timescale 1ns / 1ps
// mfsd_reading_checker: watches the word and reading channels of the meter frame
// segment decoder, rebuilds each frame, predicts its reading and compares
// depends on mfsd_pkg
module mfsd_reading_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_rx_byte,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic       m_negative,
    input  logic [3:0] m_digit_3,
    input  logic [3:0] m_digit_2,
    input  logic [3:0] m_digit_1,
    input  logic [3:0] m_digit_0,
    input  logic [3:0] m_decimal_points,
    input  logic [7:0] m_unit_prefix_flags,
    input  logic [7:0] m_unit_flags,
    input  logic [7:0] m_mode_flags,
    input  logic [7:0] m_hold_flags,
    input  logic [7:0] m_extra_flags,
    output int         readings_pending,
    output int         failures
);

    typedef enum logic [3:0] {
        DIG_BLANK, DIG_0, DIG_1, DIG_2, DIG_3, DIG_4, DIG_5, DIG_6, DIG_7, DIG_8, DIG_9,
        DIG_L, DIG_UNKNOWN
    } digit_code_t;

    typedef struct packed {
        logic       negative;
        logic [3:0] digit_3;
        logic [3:0] digit_2;
        logic [3:0] digit_1;
        logic [3:0] digit_0;
        logic [3:0] decimal_points;
        logic [7:0] unit_prefix_flags;
        logic [7:0] unit_flags;
        logic [7:0] mode_flags;
        logic [7:0] hold_flags;
        logic [7:0] extra_flags;
    } reading_t;

    logic [7:0]  sync_value = mfsd_pkg::SYNC_RESET;
    logic [7:0]  frame_bytes [mfsd_pkg::FRAME_LENGTH];
    int unsigned frame_pos = 0;
    reading_t    expected_readings [$];
    reading_t    predicted;
    reading_t    seen;
    reading_t    oldest;

    function automatic logic [3:0] segment_code(input logic [7:0] w);
        case (w[6:0])
            7'h00: segment_code = DIG_BLANK;
            7'h5F: segment_code = DIG_0;
            7'h06: segment_code = DIG_1;
            7'h6B: segment_code = DIG_2;
            7'h2F: segment_code = DIG_3;
            7'h36: segment_code = DIG_4;
            7'h3D: segment_code = DIG_5;
            7'h7D: segment_code = DIG_6;
            7'h07: segment_code = DIG_7;
            7'h7F: segment_code = DIG_8;
            7'h3F: segment_code = DIG_9;
            7'h58: segment_code = DIG_L;
            default: segment_code = DIG_UNKNOWN;
        endcase
    endfunction

    function automatic string reading_text(input reading_t r);
        return $sformatf(
            "neg=%0d digits=%0d,%0d,%0d,%0d dp=%h pre=%h unit=%h mode=%h hold=%h extra=%h",
            r.negative, r.digit_3, r.digit_2, r.digit_1, r.digit_0,
            r.decimal_points, r.unit_prefix_flags, r.unit_flags,
            r.mode_flags, r.hold_flags, r.extra_flags);
    endfunction

    task automatic report_failure(input string msg);
        failures++;
        if (failures <= 10) begin
            $display("%0t: %s", $realtime, msg);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            sync_value = mfsd_pkg::SYNC_RESET;
            frame_pos = 0;
            expected_readings.delete();
        end else begin
            if (s_valid && s_ready) begin
                if (s_rx_byte == sync_value) begin
                    frame_pos = 0;
                end
                frame_bytes[frame_pos] = s_rx_byte;
                frame_pos++;
                if (frame_pos == mfsd_pkg::FRAME_LENGTH) begin
                    frame_pos = 0;
                    predicted.negative          =
                        (frame_bytes[mfsd_pkg::POS_MODE] & mfsd_pkg::SIGN_MASK) != 8'h00;
                    predicted.digit_3           = segment_code(frame_bytes[mfsd_pkg::POS_DIGIT3]);
                    predicted.digit_2           = segment_code(frame_bytes[mfsd_pkg::POS_DIGIT2]);
                    predicted.digit_1           = segment_code(frame_bytes[mfsd_pkg::POS_DIGIT1]);
                    predicted.digit_0           = segment_code(frame_bytes[mfsd_pkg::POS_DIGIT0]);
                    predicted.decimal_points    = {frame_bytes[mfsd_pkg::POS_DIGIT3][7],
                                                   frame_bytes[mfsd_pkg::POS_DIGIT2][7],
                                                   frame_bytes[mfsd_pkg::POS_DIGIT1][7],
                                                   frame_bytes[mfsd_pkg::POS_DIGIT0][7]};
                    predicted.unit_prefix_flags = frame_bytes[mfsd_pkg::POS_PREFIX];
                    predicted.unit_flags        = frame_bytes[mfsd_pkg::POS_UNIT];
                    predicted.mode_flags        =
                        frame_bytes[mfsd_pkg::POS_MODE] & mfsd_pkg::MODE_MASK;
                    predicted.hold_flags        =
                        frame_bytes[mfsd_pkg::POS_HOLD] & mfsd_pkg::HOLD_MASK;
                    predicted.extra_flags       =
                        frame_bytes[mfsd_pkg::POS_EXTRA] & mfsd_pkg::EXTRA_MASK;
                    expected_readings.push_back(predicted);
                end
            end

            // a write takes effect for words after this edge
            if (cfg_wr_en) begin
                sync_value = cfg_wr_data;
            end

            if (m_valid && m_ready) begin
                seen = {m_negative, m_digit_3, m_digit_2, m_digit_1, m_digit_0,
                        m_decimal_points, m_unit_prefix_flags, m_unit_flags,
                        m_mode_flags, m_hold_flags, m_extra_flags};
                if (expected_readings.size() == 0) begin
                    report_failure({"reading with none expected: ", reading_text(seen)});
                end else begin
                    oldest = expected_readings.pop_front();
                    if (seen !== oldest) begin
                        report_failure({"reading mismatch\n  expected ", reading_text(oldest),
                                        "\n  actual   ", reading_text(seen)});
                    end
                end
            end
        end
        readings_pending = expected_readings.size();
    end

endmodule

FILE: test/meter_frame_segment_decoder_tb.sv
`timescale 1ns / 1ps
// meter_frame_segment_decoder_tb: drives link words and sync settings into the
// decoder under several idle patterns
// depends on mfsd_pkg, the decoder and mfsd_reading_checker
module meter_frame_segment_decoder_tb;

    localparam int PHASE_WORDS = 400;
    localparam int HOLD_CYCLES = 300;

    // sync restart mid-frame, then a frame of field extremes
    localparam logic [7:0] OPENING [26] = '{
        mfsd_pkg::SYNC_RESET, 8'h01, 8'hFF, 8'h55,
        mfsd_pkg::SYNC_RESET, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h80, 8'hFF, 8'h58, 8'h5F, 8'hFF,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        8'hFF, 8'hFF, 8'h00, 8'hFF
    };

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       cfg_wr_en = 1'b0;
    logic [7:0] cfg_wr_data = 8'h00;
    logic       s_valid = 1'b0;
    logic       s_ready;
    logic [7:0] s_rx_byte = 8'h00;
    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_negative;
    logic [3:0] m_digit_3;
    logic [3:0] m_digit_2;
    logic [3:0] m_digit_1;
    logic [3:0] m_digit_0;
    logic [3:0] m_decimal_points;
    logic [7:0] m_unit_prefix_flags;
    logic [7:0] m_unit_flags;
    logic [7:0] m_mode_flags;
    logic [7:0] m_hold_flags;
    logic [7:0] m_extra_flags;

    int         readings_pending;
    int         failures;
    int         sender_idle_pct = 0;
    int         receiver_stall_pct = 0;
    int         hold_req = 0;
    int         hold_seen = 0;
    int         hold_left = 0;
    int         words_sent = 0;
    logic [7:0] sync_now = mfsd_pkg::SYNC_RESET;

    always #1 aclk = ~aclk;

    meter_frame_segment_decoder u_dut (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_negative          (m_negative),
        .m_digit_3           (m_digit_3),
        .m_digit_2           (m_digit_2),
        .m_digit_1           (m_digit_1),
        .m_digit_0           (m_digit_0),
        .m_decimal_points    (m_decimal_points),
        .m_unit_prefix_flags (m_unit_prefix_flags),
        .m_unit_flags        (m_unit_flags),
        .m_mode_flags        (m_mode_flags),
        .m_hold_flags        (m_hold_flags),
        .m_extra_flags       (m_extra_flags)
    );

    mfsd_reading_checker u_checker (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .cfg_wr_en           (cfg_wr_en),
        .cfg_wr_data         (cfg_wr_data),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_rx_byte           (s_rx_byte),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_negative          (m_negative),
        .m_digit_3           (m_digit_3),
        .m_digit_2           (m_digit_2),
        .m_digit_1           (m_digit_1),
        .m_digit_0           (m_digit_0),
        .m_decimal_points    (m_decimal_points),
        .m_unit_prefix_flags (m_unit_prefix_flags),
        .m_unit_flags        (m_unit_flags),
        .m_mode_flags        (m_mode_flags),
        .m_hold_flags        (m_hold_flags),
        .m_extra_flags       (m_extra_flags),
        .readings_pending    (readings_pending),
        .failures            (failures)
    );

    // reading receiver, with one long hold-off
    always @(negedge aclk) begin
        if (hold_req != hold_seen) begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic send_word(input logic [7:0] w);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        words_sent++;
    endtask

    function automatic logic [7:0] frame_byte(input int pos);
        logic [7:0] w;
        do begin
            if (pos >= mfsd_pkg::POS_DIGIT0 && pos <= mfsd_pkg::POS_DIGIT3
                    && $urandom_range(3) != 0) begin
                w = {1'($urandom_range(1)),
                     mfsd_pkg::SEG_TABLE[$urandom_range(mfsd_pkg::SEG_COUNT - 1)]};
            end else begin
                w = 8'($urandom);
            end
        end while (w == sync_now);
        return w;
    endfunction

    task automatic send_frame(input bit with_sync);
        for (int pos = 0; pos < mfsd_pkg::FRAME_LENGTH; pos++) begin
            if (pos == 0 && with_sync) begin
                send_word(sync_now);
            end else begin
                send_word(frame_byte(pos));
            end
        end
    endtask

    task automatic write_sync(input logic [7:0] value);
        s_valid <= 1'b0;
        do @(negedge aclk); while (readings_pending != 0);
        repeat (4) @(negedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        sync_now = value;
    endtask

    initial begin
        int          target;
        int unsigned kind;

        repeat (2) @(negedge aclk);
        aresetn <= 1'b1;

        foreach (OPENING[i]) begin
            send_word(OPENING[i]);
        end

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 0;
                    hold_req++;
                    repeat (3) send_frame(1'b1);
                end
                1: begin
                    sender_idle_pct = 61;
                    receiver_stall_pct = 0;
                    write_sync(8'h00);
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct = 61;
                    write_sync(8'hFF);
                end
                default: begin
                    sender_idle_pct = 31;
                    receiver_stall_pct = 31;
                    write_sync(8'($urandom));
                end
            endcase

            target = words_sent + PHASE_WORDS;
            while (words_sent < target) begin
                kind = $urandom_range(99);
                if (kind < 70) begin
                    send_frame(1'b1);
                end else if (kind < 80) begin
                    send_frame(1'b0);
                end else if (kind < 90) begin
                    send_word(sync_now);
                    repeat ($urandom_range(1, 20)) send_word(frame_byte(0));
                end else begin
                    repeat ($urandom_range(1, 8)) send_word(8'($urandom));
                end
            end
        end

        s_valid <= 1'b0;
        do @(negedge aclk); while (readings_pending != 0);
        repeat (10) @(negedge aclk);
        if (failures == 0 && readings_pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #1000000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
